/* rtl/gcsp_pkg.sv */
// Package for the generation-checked slot pool: sizes, field layout, codes and types.
// Used by every module of the block; it depends on nothing.
package gcsp_pkg;

  localparam int SLOTS     = 16;
  localparam int GEN_BITS  = 16;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = 7;
  localparam int SLOT_W    = 6;
  localparam int LGEN_W    = 16;
  localparam int GEN_EXT_W = (GEN_BITS > LGEN_W) ? GEN_BITS : LGEN_W;
  localparam int ACTION_W  = 2;
  localparam int DROP_W    = 32;

  localparam int IN_W  = 24;
  localparam int OUT_W = 64;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CNT_W-1:0] SLOTS_IN_USE_RST = CNT_W'(16);
  localparam logic             REG_SLOTS_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    PH_FREE       = 2'd0,
    PH_COPYING    = 2'd1,
    PH_CONVERTING = 2'd2
  } phase_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_HANDOFF = 2'd1,
    ACT_ABORT   = 2'd2,
    ACT_RELEASE = 2'd3
  } action_e;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    phase_e              phase;
    logic                gen_en;
    logic [GEN_BITS-1:0] gen;
  } slot_wr_t;

endpackage

/* rtl/generation_checked_slot_pool_unit.sv */
// Top level of the generation-checked slot pool: sequencer, counters and bus ports.
// Depends on gcsp_pkg and gcsp_slot_table.
// Each accepted word is checked against the slots one by one through the single table read
// port, then an update step writes the table and registers the result. A new word is taken
// only after the result has been handed off. Reset clears all slots to free with generation
// zero, the drop count to zero and the slot count to 16, with no clearing pass.
module generation_checked_slot_pool_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // action [1:0], lease_slot [7:2], lease_generation [23:8]
  input  logic [gcsp_pkg::IN_W-1:0]        s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // ok [0], granted_slot [6:1], granted_generation [22:7], busy_count [29:23],
  // drop_total [61:30], zero fill [63:62]
  output logic [gcsp_pkg::OUT_W-1:0]       m_axis_tdata_o,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [gcsp_pkg::APB_ADDR_W-1:0]  paddr_i,
  input  logic [gcsp_pkg::APB_DATA_W-1:0]  pwdata_i,
  output logic [gcsp_pkg::APB_DATA_W-1:0]  prdata_o,
  output logic                             pready_o
);
  import gcsp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_OUT
  } state_e;

  state_e              state_q;
  action_e             action_q;
  logic [SLOT_W-1:0]   lslot_q;
  logic [LGEN_W-1:0]   lgen_q;
  logic [IDX_W-1:0]    idx_q;
  logic                found_q;
  logic [IDX_W-1:0]    hit_q;
  logic [GEN_BITS-1:0] newgen_q;
  logic [CNT_W-1:0]    busy_q;
  logic [DROP_W-1:0]   drop_q;
  logic [DROP_W-1:0]   drop_d;
  logic [CNT_W-1:0]    cfg_q;

  logic                out_ok_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [LGEN_W-1:0]   out_gen_q;
  logic [CNT_W-1:0]    out_busy_q;
  logic [DROP_W-1:0]   out_drop_q;

  phase_e              rd_phase;
  logic [GEN_BITS-1:0] rd_gen;
  logic [GEN_EXT_W-1:0] rd_gen_ext;
  logic [GEN_EXT_W-1:0] newgen_ext;
  slot_wr_t            wr;

  logic [CNT_W-1:0]    n_usable;
  logic [CNT_W-1:0]    idx_ext;
  logic                in_range;
  phase_e              want;
  logic                acq_hit;
  logic                lease_hit;
  logic                is_acq;
  logic                last_idx;
  logic [CNT_W-1:0]    busy_res;
  logic                cfg_wr;

  gcsp_slot_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_phase_o (rd_phase),
    .rd_gen_o   (rd_gen),
    .wr_i       (wr)
  );

  // Configuration port.
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_SLOTS_IN_USE);
  assign prdata_o = (paddr_i[2] == REG_SLOTS_IN_USE) ? APB_DATA_W'(cfg_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= SLOTS_IN_USE_RST;
    end else if (cfg_wr) begin
      cfg_q <= pwdata_i[CNT_W-1:0];
    end
  end

  // Scan-step comparisons against the slot under the read port.
  assign n_usable   = (cfg_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cfg_q;
  assign idx_ext    = CNT_W'(idx_q);
  assign in_range   = idx_ext < n_usable;
  assign rd_gen_ext = GEN_EXT_W'(rd_gen);
  assign newgen_ext = GEN_EXT_W'(newgen_q);
  assign is_acq     = (action_q == ACT_ACQUIRE);
  assign want       = (action_q == ACT_RELEASE) ? PH_CONVERTING : PH_COPYING;
  assign acq_hit    = is_acq && in_range && (rd_phase == PH_FREE) && !found_q;
  assign lease_hit  = !is_acq && in_range && (idx_ext == CNT_W'(lslot_q)) &&
                      (rd_gen_ext[LGEN_W-1:0] == lgen_q) && (rd_phase == want);
  assign last_idx   = (idx_q == IDX_W'(SLOTS - 1));

  always_comb begin
    wr.en     = (state_q == ST_APPLY) && found_q;
    wr.idx    = hit_q;
    wr.gen_en = is_acq;
    wr.gen    = newgen_q;
    case (action_q)
      ACT_ACQUIRE: wr.phase = PH_COPYING;
      ACT_HANDOFF: wr.phase = PH_CONVERTING;
      default:     wr.phase = PH_FREE;
    endcase
  end

  always_comb begin
    busy_res = busy_q;
    if (found_q) begin
      case (action_q)
        ACT_ACQUIRE: busy_res = busy_q + CNT_W'(1);
        ACT_HANDOFF: busy_res = busy_q;
        default:     busy_res = busy_q - CNT_W'(1);
      endcase
    end
  end

  assign drop_d = (is_acq && !found_q && (drop_q != '1)) ? drop_q + DROP_W'(1) : drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      action_q   <= ACT_ACQUIRE;
      lslot_q    <= '0;
      lgen_q     <= '0;
      idx_q      <= '0;
      found_q    <= 1'b0;
      hit_q      <= '0;
      newgen_q   <= '0;
      busy_q     <= '0;
      drop_q     <= '0;
      out_ok_q   <= 1'b0;
      out_slot_q <= '0;
      out_gen_q  <= '0;
      out_busy_q <= '0;
      out_drop_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            action_q <= action_e'(s_axis_tdata_i[1:0]);
            lslot_q  <= s_axis_tdata_i[7:2];
            lgen_q   <= s_axis_tdata_i[23:8];
            idx_q    <= '0;
            found_q  <= 1'b0;
            busy_q   <= '0;
            state_q  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (in_range && (rd_phase != PH_FREE)) begin
            busy_q <= busy_q + CNT_W'(1);
          end
          if (acq_hit || lease_hit) begin
            found_q  <= 1'b1;
            hit_q    <= idx_q;
            newgen_q <= rd_gen + GEN_BITS'(1);
          end
          if (last_idx) begin
            state_q <= ST_APPLY;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        ST_APPLY: begin
          drop_q     <= drop_d;
          out_ok_q   <= found_q;
          out_slot_q <= (is_acq && found_q) ? SLOT_W'(hit_q) : '0;
          out_gen_q  <= (is_acq && found_q) ? newgen_ext[LGEN_W-1:0] : '0;
          out_busy_q <= busy_res;
          out_drop_q <= drop_d;
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = {2'b00, out_drop_q, out_busy_q, out_gen_q, out_slot_q, out_ok_q};

endmodule

/* rtl/gcsp_slot_table.sv */
// Slot table: phase and generation of every slot, one read port and one write port.
// Depends on gcsp_pkg.
module gcsp_slot_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [gcsp_pkg::IDX_W-1:0]   rd_idx_i,
  output gcsp_pkg::phase_e             rd_phase_o,
  output logic [gcsp_pkg::GEN_BITS-1:0] rd_gen_o,
  input  gcsp_pkg::slot_wr_t           wr_i
);
  import gcsp_pkg::*;

  phase_e              phase_q [SLOTS];
  logic [GEN_BITS-1:0] gen_q   [SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        phase_q[i] <= PH_FREE;
        gen_q[i]   <= '0;
      end
    end else if (wr_i.en) begin
      phase_q[wr_i.idx] <= wr_i.phase;
      if (wr_i.gen_en) begin
        gen_q[wr_i.idx] <= wr_i.gen;
      end
    end
  end

  assign rd_phase_o = phase_q[rd_idx_i];
  assign rd_gen_o   = gen_q[rd_idx_i];

endmodule

/* rtl/gcsp_checker.sv */
// Port-level checks for the generation-checked slot pool, bound to its top level.
// Depends on gcsp_pkg and generation_checked_slot_pool_unit.
module gcsp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [gcsp_pkg::OUT_W-1:0]      m_axis_tdata_o
);
  import gcsp_pkg::*;

  // One word is in flight at a time, so input and output are never open together.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after an accepted word");

  a_fail_zero_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |-> (m_axis_tdata_o[22:1] == '0))
    else $error("failed action reports a granted slot or generation");

  a_busy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[29:23] <= CNT_W'(SLOTS)))
    else $error("busy count exceeds the pool size");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind generation_checked_slot_pool_unit gcsp_checker u_gcsp_checker (.*);
